// ===== sv/srr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg: shared constants and types for the selective-repeat receiver
// Holds the protocol sizing, the result kinds and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package srr_pkg;

    // Total number of frames in one transfer, 1 to 256.
    localparam int TOTAL_FRAMES = 16;
    // Receive window size, 1 to 16.
    localparam int WINDOW       = 4;

    // Width of a sequence number on the stream.
    localparam int SEQ_W     = 8;
    // The window base counts up to TOTAL_FRAMES inclusive.
    localparam int BASE_W    = $clog2(TOTAL_FRAMES + 1);
    // Index into the window-relative received bits.
    localparam int WIN_IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    // Width used for the signed distance of a sequence number from the base.
    localparam int DIFF_W    = ((SEQ_W > BASE_W) ? SEQ_W : BASE_W) + 1;

    // Result kinds carried on the output tuser.
    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_DLV = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // Capture the incoming frame and mark it.
        logic emit_ack;  // Load the acknowledgment into the output register.
        logic emit_dlv;  // Load one in-order delivery and advance the base.
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // Output register can take a word this cycle.
        logic dlv_pending;  // The captured frame released at least one delivery.
        logic dlv_more;     // Another delivery follows the one at the base.
    } t_dp_sts;

endpackage

// ===== sv/srr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_dp: receiver datapath
// Holds the window base, the received bits relative to the base, the captured
// frame and the output register of the result stream.
// ----------------------------------------------------------------------------
module srr_dp
    import srr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic [SEQ_W-1:0] i_frame_seq,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_out_kind,
    output logic [SEQ_W-1:0] o_out_seq,
    output logic             o_out_dup,
    output logic             o_out_done,
    output logic             o_out_last
);

    localparam logic [BASE_W-1:0] TOTAL_B = BASE_W'(TOTAL_FRAMES);

    logic [BASE_W-1:0] r_base, n_base;
    logic [WINDOW-1:0] r_win,  n_win;
    logic [WINDOW-1:0] win_shift;
    logic [SEQ_W-1:0]  r_seq;
    logic              r_inwin;

    logic              r_out_valid, n_out_valid;
    logic              r_out_kind;
    logic [SEQ_W-1:0]  r_out_seq;
    logic              r_out_dup;
    logic              r_out_done;
    logic              r_out_last;

    logic [DIFF_W-1:0]    diff;
    logic                 in_window;
    logic [WIN_IDX_W-1:0] win_idx;
    logic [BASE_W-1:0]    base_inc;

    // Window test for the incoming frame.
    assign diff      = DIFF_W'(i_frame_seq) - DIFF_W'(r_base);
    assign in_window = !diff[DIFF_W-1]
                       && (diff < DIFF_W'(WINDOW))
                       && (DIFF_W'(i_frame_seq) < DIFF_W'(TOTAL_FRAMES));
    assign win_idx   = diff[WIN_IDX_W-1:0];

    assign win_shift = r_win >> 1;
    assign base_inc  = r_base + 1'b1;

    // Status toward the controller.
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.dlv_pending = r_inwin && r_win[0];
    assign o_sts.dlv_more    = win_shift[0];

    // Next state of the window: mark on capture, slide on delivery.
    always_comb begin
        n_base = r_base;
        n_win  = r_win;
        if (i_cmd.accept && in_window) begin
            n_win[win_idx] = 1'b1;
        end
        if (i_cmd.emit_dlv) begin
            n_win  = win_shift;
            n_base = base_inc;
        end
    end

    // Output word is held until taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit_ack || i_cmd.emit_dlv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_base      <= n_base;
            r_win       <= n_win;
            r_out_valid <= n_out_valid;
        end
    end

    // Captured frame.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_seq   <= i_frame_seq;
            r_inwin <= in_window;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ack) begin
            r_out_kind <= KIND_ACK;
            r_out_seq  <= r_seq;
            r_out_dup  <= !r_inwin;
            r_out_done <= (r_base == TOTAL_B);
            r_out_last <= !(r_inwin && r_win[0]);
        end else if (i_cmd.emit_dlv) begin
            r_out_kind <= KIND_DLV;
            r_out_seq  <= SEQ_W'(r_base);
            r_out_dup  <= 1'b0;
            r_out_done <= (base_inc == TOTAL_B);
            r_out_last <= !win_shift[0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_seq   = r_out_seq;
    assign o_out_dup   = r_out_dup;
    assign o_out_done  = r_out_done;
    assign o_out_last  = r_out_last;

    // The base never runs past the end of the transfer.
    a_base_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= TOTAL_B)
        else $error("window base beyond total frame count");

    // A delivery is only issued for a frame received at the base.
    a_dlv_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_dlv |-> (r_win[0] && (r_base < TOTAL_B)))
        else $error("delivery of a frame not received");

    // A delivery advances the base by exactly one.
    a_dlv_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_dlv |=> (r_base == $past(base_inc)))
        else $error("base did not advance after delivery");

    // A result is never loaded over a word that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_ack || i_cmd.emit_dlv) |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");

endmodule

// ===== sv/srr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_ctrl: receiver controller
// Sequences one frame: capture, acknowledgment, then in-order deliveries one
// per cycle while the output register can take them.
// ----------------------------------------------------------------------------
module srr_ctrl
    import srr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACK  = 2'd1;
    localparam logic [1:0] ST_DLV  = 2'd2;

    logic [1:0] r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_ACK;
                end
            end
            ST_ACK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ack = 1'b1;
                    n_state        = i_sts.dlv_pending ? ST_DLV : ST_IDLE;
                end
            end
            ST_DLV: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_dlv = 1'b1;
                    n_state        = i_sts.dlv_more ? ST_DLV : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // At most one datapath command per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("conflicting datapath commands");

    // Every captured frame is followed by its acknowledgment step.
    a_accept_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == ST_ACK))
        else $error("capture not followed by acknowledgment");

    // Deliveries only follow an acknowledgment or another delivery.
    a_dlv_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DLV) |-> ($past(o_cmd.emit_ack) || $past(o_cmd.emit_dlv)
                                 || $past(r_state == ST_DLV)))
        else $error("delivery without preceding acknowledgment");

endmodule

// ===== sv/selective_repeat_receiver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receiver_core: selective-repeat ARQ receiver
// Acknowledges each arriving frame number and releases received frames in
// order from the window base, one result word per cycle while not stalled.
// ----------------------------------------------------------------------------
// Each accepted frame produces an acknowledgment word followed by zero to
// WINDOW delivery words, the last one flagged on tlast. A frame is handled
// in steps: capture and mark it, load the acknowledgment, then load each
// delivery that it releases, all going through a single output register
// paced by the controller. The next frame is taken as soon as the controller
// is back in idle, even while the final word of the previous frame still
// waits to be read. The received-frame state starts clear after reset with
// no clearing pass.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_core
    import srr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Frame input.
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] frame_seq
    // Result output.
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] result_seq, [8] duplicate,
                                             // [9] all_done, [15:10] zero
    output logic             m_axis_tuser,   // [0] result_kind
    output logic             m_axis_tlast    // last
);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [SEQ_W-1:0] out_seq;
    logic             out_dup;
    logic             out_done;

    // Frame sequencing.
    srr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Window state and output register.
    srr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_frame_seq (s_axis_tdata[SEQ_W-1:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_seq   (out_seq),
        .o_out_dup   (out_dup),
        .o_out_done  (out_done),
        .o_out_last  (m_axis_tlast)
    );

    // Pack the result word.
    assign m_axis_tdata = {6'b0, out_done, out_dup, out_seq};

endmodule
